/* sv/nmcc_pkg.sv */
package nmcc_pkg;

	// channel and stream widths
	localparam int CHAN_BITS  = 8;
	localparam int NUM_CHAN   = 3;
	localparam int TDATA_BITS = CHAN_BITS * NUM_CHAN;

	// sum of three squares of 8-bit channels fits in 18 bits, its root in 9
	localparam int SUM_BITS   = 18;
	localparam int ROOT_BITS  = 9;
	localparam int TRIAL_BITS = SUM_BITS + 2;
	localparam int PROD_BITS  = CHAN_BITS + ROOT_BITS;

	localparam logic [CHAN_BITS-1:0] CHAN_MAX = 8'hFF;
	// floor root of 3 * 255 * 255
	localparam logic [ROOT_BITS-1:0] ROOT_MAX = 9'd441;

	typedef logic [CHAN_BITS-1:0]               chan_t;
	typedef logic [NUM_CHAN-1:0][CHAN_BITS-1:0] rgb_t;
	typedef logic [SUM_BITS-1:0]                sum_t;
	typedef logic [ROOT_BITS-1:0]               root_t;
	typedef logic [PROD_BITS-1:0]               prod_t;

endpackage

/* sv/nmcc_isqrt.sv */
module nmcc_isqrt (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_vld,
	input  nmcc_pkg::sum_t  sum_a,
	input  nmcc_pkg::sum_t  sum_b,
	input  nmcc_pkg::rgb_t  side_in,
	output logic          out_vld,
	output nmcc_pkg::root_t root_a,
	output nmcc_pkg::root_t root_b,
	output nmcc_pkg::rgb_t  side_out
);
	import nmcc_pkg::*;

	// one root bit per stage, msb first
	localparam int STAGES = ROOT_BITS;

	typedef struct packed {
		sum_t  rem;
		root_t root;
	} sq_t;

	// rem holds value minus root squared; try setting root bit bitpos
	function automatic sq_t sq_step(sq_t cur, int unsigned bitpos);
		logic [TRIAL_BITS-1:0] trial;
		sq_t                   nxt;
		trial = (TRIAL_BITS'(cur.root) << (bitpos + 1)) + (TRIAL_BITS'(1) << (2 * bitpos));
		nxt   = cur;
		if (TRIAL_BITS'(cur.rem) >= trial) begin
			nxt.rem  = cur.rem - trial[SUM_BITS-1:0];
			nxt.root = cur.root | (ROOT_BITS'(1) << bitpos);
		end
		return nxt;
	endfunction

	logic vld_s  [STAGES];
	sq_t  sq_a_s [STAGES];
	sq_t  sq_b_s [STAGES];
	rgb_t side_s [STAGES];

	genvar k;
	for (k = 0; k < STAGES; k++) begin : g_stage
		sq_t  in_a;
		sq_t  in_b;
		rgb_t in_side;
		logic in_v;

		// stage input from the port or the previous stage
		if (k == 0) begin : g_first
			assign in_a    = '{rem: sum_a, root: '0};
			assign in_b    = '{rem: sum_b, root: '0};
			assign in_side = side_in;
			assign in_v    = in_vld;
		end else begin : g_next
			assign in_a    = sq_a_s[k-1];
			assign in_b    = sq_b_s[k-1];
			assign in_side = side_s[k-1];
			assign in_v    = vld_s[k-1];
		end

		// valid bit
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= in_v;
			end
		end

		// root step for both values
		always_ff @(posedge clk) begin
			if (en) begin
				sq_a_s[k] <= sq_step(in_a, STAGES - 1 - k);
				sq_b_s[k] <= sq_step(in_b, STAGES - 1 - k);
				side_s[k] <= in_side;
			end
		end
	end

	assign out_vld  = vld_s[STAGES-1];
	assign root_a   = sq_a_s[STAGES-1].root;
	assign root_b   = sq_b_s[STAGES-1].root;
	assign side_out = side_s[STAGES-1];

`ifndef ASSERT_OFF
	// floor root leaves a remainder of at most twice the root
	assert property (@(posedge clk) disable iff (!arst_n)
		out_vld |-> TRIAL_BITS'(sq_a_s[STAGES-1].rem) <= (TRIAL_BITS'(root_a) << 1))
		else $error("color norm remainder out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_vld |-> TRIAL_BITS'(sq_b_s[STAGES-1].rem) <= (TRIAL_BITS'(root_b) << 1))
		else $error("complement norm remainder out of range");

	// roots never exceed the norm of full white
	assert property (@(posedge clk) disable iff (!arst_n)
		out_vld |-> root_a <= ROOT_MAX && root_b <= ROOT_MAX)
		else $error("norm above maximum");
`endif

endmodule

/* sv/nmcc_div.sv */
module nmcc_div (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_vld,
	input  nmcc_pkg::rgb_t  comp,
	input  nmcc_pkg::root_t num,
	input  nmcc_pkg::root_t den,
	output logic          out_vld,
	output nmcc_pkg::rgb_t  res
);
	import nmcc_pkg::*;

	// one quotient bit per stage, msb first
	localparam int STAGES = CHAN_BITS;

	typedef struct packed {
		prod_t rem;
		chan_t quo;
		logic  sat;
	} dv_t;

	typedef dv_t [NUM_CHAN-1:0] dv_row_t;

	// restoring step; the first step also flags quotients above the channel range
	function automatic dv_t dv_step(dv_t cur, root_t d, int unsigned bitpos, bit first);
		prod_t dshift;
		dv_t   nxt;
		dshift = PROD_BITS'(d) << bitpos;
		nxt    = cur;
		if (first) begin
			nxt.sat = cur.rem >= (PROD_BITS'(d) << CHAN_BITS);
		end
		if (cur.rem >= dshift) begin
			nxt.rem         = cur.rem - dshift;
			nxt.quo[bitpos] = 1'b1;
		end
		return nxt;
	endfunction

	// product stage
	logic                       prod_vld_s;
	logic [NUM_CHAN-1:0][PROD_BITS-1:0] prod_s;
	root_t                      prod_den_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_vld_s <= 1'b0;
		end else if (en) begin
			prod_vld_s <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < NUM_CHAN; c++) begin
				prod_s[c] <= PROD_BITS'(comp[c]) * PROD_BITS'(num);
			end
			prod_den_s <= den;
		end
	end

	logic    vld_s [STAGES];
	dv_row_t dv_s  [STAGES];
	root_t   den_s [STAGES];

	genvar k;
	for (k = 0; k < STAGES; k++) begin : g_stage
		dv_row_t in_dv;
		root_t   in_den;
		logic    in_v;

		// stage input from the product stage or the previous stage
		if (k == 0) begin : g_first
			always_comb begin
				for (int c = 0; c < NUM_CHAN; c++) begin
					in_dv[c] = '{rem: prod_s[c], quo: '0, sat: 1'b0};
				end
			end
			assign in_den = prod_den_s;
			assign in_v   = prod_vld_s;
		end else begin : g_next
			assign in_dv  = dv_s[k-1];
			assign in_den = den_s[k-1];
			assign in_v   = vld_s[k-1];
		end

		// valid bit
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= in_v;
			end
		end

		// quotient bit for all channels
		always_ff @(posedge clk) begin
			if (en) begin
				for (int c = 0; c < NUM_CHAN; c++) begin
					dv_s[k][c] <= dv_step(in_dv[c], in_den, STAGES - 1 - k, k == 0);
				end
				den_s[k] <= in_den;
			end
		end
	end

	// saturate; a zero divisor gives all ones on its own
	assign out_vld = vld_s[STAGES-1];
	always_comb begin
		for (int c = 0; c < NUM_CHAN; c++) begin
			res[c] = dv_s[STAGES-1][c].sat ? CHAN_MAX : dv_s[STAGES-1][c].quo;
		end
	end

`ifndef ASSERT_OFF
	// white input: zero complement means zero products
	assert property (@(posedge clk) disable iff (!arst_n)
		prod_vld_s && prod_den_s == '0 |-> prod_s == '0)
		else $error("nonzero product with zero complement norm");

	// white input comes out as all ones
	assert property (@(posedge clk) disable iff (!arst_n)
		out_vld && den_s[STAGES-1] == '0 |-> res == {NUM_CHAN{CHAN_MAX}})
		else $error("white input not saturated");

	// unsaturated quotients leave a remainder below the divisor
	assert property (@(posedge clk) disable iff (!arst_n)
		out_vld && den_s[STAGES-1] != '0 |->
			(dv_s[STAGES-1][0].sat || dv_s[STAGES-1][0].rem < PROD_BITS'(den_s[STAGES-1])) &&
			(dv_s[STAGES-1][1].sat || dv_s[STAGES-1][1].rem < PROD_BITS'(den_s[STAGES-1])) &&
			(dv_s[STAGES-1][2].sat || dv_s[STAGES-1][2].rem < PROD_BITS'(den_s[STAGES-1])))
		else $error("division remainder too large");
`endif

endmodule

/* sv/norm_matched_color_complement.sv */
// pipeline from an accepted item to m_tvalid:
// 1 squares stage, 9 root stages, 1 product stage, 8 quotient stages
// throughput: one item per cycle; the whole pipe holds while m_tvalid is high and m_tready low
// reset: arst_n clears only the valid bits, the data registers are left as they are
module norm_matched_color_complement (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [nmcc_pkg::TDATA_BITS-1:0]     s_tdata,  // red_in, green_in, blue_in
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [nmcc_pkg::TDATA_BITS-1:0]     m_tdata   // red_out, green_out, blue_out
);
	import nmcc_pkg::*;

	logic en;
	rgb_t in_rgb;
	rgb_t in_comp;
	sum_t in_sum_src;
	sum_t in_sum_cmp;

	// pipe advances unless a result is waiting
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;
	assign in_rgb   = rgb_t'(s_tdata);

	// complements and sums of squares
	always_comb begin
		in_sum_src = '0;
		in_sum_cmp = '0;
		for (int c = 0; c < NUM_CHAN; c++) begin
			in_comp[c] = CHAN_MAX - in_rgb[c];
			in_sum_src = in_sum_src + SUM_BITS'(16'(in_rgb[c]) * 16'(in_rgb[c]));
			in_sum_cmp = in_sum_cmp + SUM_BITS'(16'(in_comp[c]) * 16'(in_comp[c]));
		end
	end

	logic vld_s1;
	sum_t sum_src_s1;
	sum_t sum_cmp_s1;
	rgb_t comp_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_src_s1 <= in_sum_src;
			sum_cmp_s1 <= in_sum_cmp;
			comp_s1    <= in_comp;
		end
	end

	// both norms
	logic  root_vld;
	root_t norm_src;
	root_t norm_cmp;
	rgb_t  root_comp;

	nmcc_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s1),
		.sum_a    (sum_src_s1),
		.sum_b    (sum_cmp_s1),
		.side_in  (comp_s1),
		.out_vld  (root_vld),
		.root_a   (norm_src),
		.root_b   (norm_cmp),
		.side_out (root_comp)
	);

	// scale complement by norm ratio
	rgb_t res;

	nmcc_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (root_vld),
		.comp    (root_comp),
		.num     (norm_src),
		.den     (norm_cmp),
		.out_vld (m_tvalid),
		.res     (res)
	);

	assign m_tdata = TDATA_BITS'(res);

endmodule

/* bench/nmcc_complement_checker.sv */
`timescale 1ns / 1ps

module nmcc_complement_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [nmcc_pkg::TDATA_BITS-1:0] s_tdata,   // red_in, green_in, blue_in
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [nmcc_pkg::TDATA_BITS-1:0] m_tdata,   // red_out, green_out, blue_out
	output int                              fail_count,
	output int                              pending,
	output int                              matched_count
);
	import nmcc_pkg::*;

	// red sits in the low byte, so it is the last member of the packed struct
	typedef struct packed {
		chan_t blue;
		chan_t green;
		chan_t red;
	} pixel_t;

	pixel_t due_complements[$];
	int     mismatches = 0;
	int     matched    = 0;

	// floor square root, one result bit per step from the top
	function automatic root_t floor_root(input sum_t v);
		root_t r;
		root_t t;
		r = '0;
		for (int i = ROOT_BITS - 1; i >= 0; i--) begin
			t = r | root_t'(1 << i);
			if (32'(t) * 32'(t) <= 32'(v))
				r = t;
		end
		return r;
	endfunction

	// complement channel times color norm over complement norm, clipped to a byte
	function automatic chan_t scale_to_norm(input chan_t c, input root_t num, input root_t den);
		logic [31:0] q;
		q = (32'(c) * 32'(num)) / 32'(den);
		return (q > 32'(CHAN_MAX)) ? CHAN_MAX : chan_t'(q);
	endfunction

	function automatic pixel_t complement_of(input pixel_t src);
		pixel_t cmp;
		pixel_t res;
		root_t  norm_src;
		root_t  norm_cmp;
		cmp.red   = CHAN_MAX - src.red;
		cmp.green = CHAN_MAX - src.green;
		cmp.blue  = CHAN_MAX - src.blue;
		norm_src = floor_root(sum_t'(32'(src.red) * 32'(src.red)
			+ 32'(src.green) * 32'(src.green) + 32'(src.blue) * 32'(src.blue)));
		norm_cmp = floor_root(sum_t'(32'(cmp.red) * 32'(cmp.red)
			+ 32'(cmp.green) * 32'(cmp.green) + 32'(cmp.blue) * 32'(cmp.blue)));
		// white input leaves no complement to scale
		if (norm_cmp == '0) begin
			res.red   = CHAN_MAX;
			res.green = CHAN_MAX;
			res.blue  = CHAN_MAX;
		end else begin
			res.red   = scale_to_norm(cmp.red,   norm_src, norm_cmp);
			res.green = scale_to_norm(cmp.green, norm_src, norm_cmp);
			res.blue  = scale_to_norm(cmp.blue,  norm_src, norm_cmp);
		end
		return res;
	endfunction

	// watch both channels, queue predictions and compare in order
	always @(posedge clk) begin
		pixel_t got;
		pixel_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				due_complements.push_back(complement_of(pixel_t'(s_tdata)));
			if (m_tvalid && m_tready) begin
				got = pixel_t'(m_tdata);
				if (due_complements.size() == 0) begin
					$error("unexpected output item, tdata %h", m_tdata);
					mismatches++;
				end else begin
					want = due_complements.pop_front();
					if (got.red !== want.red) begin
						$error("red_out: expected %0d, got %0d", want.red, got.red);
						mismatches++;
					end
					if (got.green !== want.green) begin
						$error("green_out: expected %0d, got %0d", want.green, got.green);
						mismatches++;
					end
					if (got.blue !== want.blue) begin
						$error("blue_out: expected %0d, got %0d", want.blue, got.blue);
						mismatches++;
					end
					matched++;
				end
			end
		end
		fail_count    <= mismatches;
		pending       <= due_complements.size();
		matched_count <= matched;
	end

endmodule

/* bench/tb_norm_matched_color_complement.sv */
`timescale 1ns / 1ps

module tb_norm_matched_color_complement;
	import nmcc_pkg::*;

	localparam int CYCLE_LIMIT  = 300000;
	localparam int ITEMS_PHASE  = 185;
	localparam int DRAIN_CYCLES = 40;
	localparam int HOLD_CYCLES  = 200;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [TDATA_BITS-1:0] s_tdata  = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [TDATA_BITS-1:0] m_tdata;

	int fail_count;
	int pending;
	int matched_count;
	int cycle_count   = 0;
	int send_idle_pct = 0;
	int stall_pct     = 0;
	bit hold_output   = 1'b0;

	norm_matched_color_complement DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	nmcc_complement_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.fail_count    (fail_count),
		.pending       (pending),
		.matched_count (matched_count)
	);

	// clock and cycle count
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// watchdog
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("Some tests failed");
		$finish;
	end

	// output side: random stalls, with a long hold-off on request
	initial begin
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_output) begin
				hold_output = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				m_tready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// offer one color and wait for it to be taken, then maybe idle
	task automatic offer_rgb(input chan_t r, input chan_t g, input chan_t b);
		s_tdata  <= {b, g, r};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(posedge clk);
		end
	endtask

	// hold the input until every predicted item has come out
	task automatic drain_outputs();
		do
			@(posedge clk);
		while (pending != 0);
	endtask

	function automatic chan_t pick_extreme();
		case ($urandom_range(5))
			0:       return 8'd0;
			1:       return 8'd1;
			2:       return 8'd127;
			3:       return 8'd128;
			4:       return 8'd254;
			default: return CHAN_MAX;
		endcase
	endfunction

	// random colors, with extremes, near-white, near-black and grays mixed in
	task automatic offer_random_color();
		chan_t r;
		chan_t g;
		chan_t b;
		int    kind;
		kind = $urandom_range(5);
		case (kind)
			2: begin
				r = pick_extreme();
				g = pick_extreme();
				b = pick_extreme();
			end
			3: begin
				r = chan_t'($urandom_range(255, 236));
				g = chan_t'($urandom_range(255, 236));
				b = chan_t'($urandom_range(255, 236));
			end
			4: begin
				r = chan_t'($urandom_range(15));
				g = chan_t'($urandom_range(15));
				b = chan_t'($urandom_range(15));
			end
			5: begin
				r = chan_t'($urandom_range(255));
				g = r ^ chan_t'($urandom_range(3));
				b = r ^ chan_t'($urandom_range(3));
			end
			default: begin
				r = chan_t'($urandom_range(255));
				g = chan_t'($urandom_range(255));
				b = chan_t'($urandom_range(255));
			end
		endcase
		offer_rgb(r, g, b);
	endtask

	// stimulus and verdict
	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: black, white, primaries, secondaries, near-white saturation, low and mid levels
		offer_rgb(8'd0,   8'd0,   8'd0);
		offer_rgb(8'd255, 8'd255, 8'd255);
		offer_rgb(8'd255, 8'd0,   8'd0);
		offer_rgb(8'd0,   8'd255, 8'd0);
		offer_rgb(8'd0,   8'd0,   8'd255);
		offer_rgb(8'd0,   8'd255, 8'd255);
		offer_rgb(8'd255, 8'd0,   8'd255);
		offer_rgb(8'd255, 8'd255, 8'd0);
		offer_rgb(8'd254, 8'd255, 8'd255);
		offer_rgb(8'd255, 8'd254, 8'd255);
		offer_rgb(8'd255, 8'd255, 8'd254);
		offer_rgb(8'd255, 8'd255, 8'd200);
		offer_rgb(8'd200, 8'd255, 8'd255);
		offer_rgb(8'd1,   8'd0,   8'd0);
		offer_rgb(8'd0,   8'd0,   8'd1);
		offer_rgb(8'd1,   8'd1,   8'd1);
		offer_rgb(8'd127, 8'd127, 8'd127);
		offer_rgb(8'd128, 8'd128, 8'd128);
		offer_rgb(8'd170, 8'd85,  8'd42);
		offer_rgb(8'd85,  8'd170, 8'd213);
		offer_rgb(8'd254, 8'd254, 8'd254);
		s_tvalid <= 1'b0;
		drain_outputs();

		// random colors under four idle and stall mixes
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0:       begin send_idle_pct = 0;  stall_pct = 0;  end
				1:       begin send_idle_pct = 54; stall_pct = 0;  end
				2:       begin send_idle_pct = 0;  stall_pct = 54; end
				default: begin send_idle_pct = 23; stall_pct = 23; end
			endcase
			// block the output long enough for the pipe to back up into the input
			if (phase == 2)
				hold_output = 1'b1;
			for (int n = 0; n < ITEMS_PHASE; n++)
				offer_random_color();
			s_tvalid <= 1'b0;
			drain_outputs();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("checked %0d output colors in %0d cycles", matched_count, cycle_count);
		$display("covered black, white, saturation, random stalls and a long output hold-off");
		if (fail_count == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
